FILE: src/grc_pkg.sv
// Shared types, constants and helper functions of the grid raycast column block.
`default_nettype none
package grc_pkg;

    // Sizes of the block
    localparam int MAP_CELLS  = 1024;
    localparam int MAX_RAYS   = 64;
    localparam int MAX_STEPS  = 8;
    localparam int CELL_SHIFT = 6;

    localparam int SHQ      = CELL_SHIFT + 8;
    localparam int ADDR_W   = $clog2(MAP_CELLS);
    localparam int STEP_W   = $clog2(MAX_STEPS + 1);

    // Field widths
    localparam int POS_IN_W = 19;
    localparam int ANG_W    = 13;
    localparam int TILE_W   = 8;
    localparam int CNT_W    = 7;
    localparam int CDATA_W  = 8;
    localparam int CIDX_W   = 2;

    // Internal widths
    localparam int POS_W    = 40;
    localparam int CELLC_W  = POS_W - 1 - SHQ;
    localparam int TRIG_W   = 18;
    localparam int CX_W     = 20;
    localparam int CZ_W     = 21;
    localparam int RATIO_W  = 35;
    localparam int DIVN_W   = 33;
    localparam int DIVD_W   = 17;
    localparam int DCNT_W   = $clog2(DIVN_W + 1);
    localparam int SQ_W     = 42;
    localparam int ROOT_W   = 21;
    localparam int MUL_A_W  = 22;
    localparam int MUL_B_W  = 35;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int WHOLE_W  = ROOT_W - 8;

    // Angles and screen
    localparam int FULL_TURN    = 5760;
    localparam int QUARTER_TURN = 1440;
    localparam int DEG_UNITS    = 16;
    localparam int ONE_Q16      = 65536;
    localparam int SCREEN_H     = 320;
    localparam int SCREEN_MID   = 160;
    localparam int POS_MAX      = 524287;
    localparam int CELL_Q8      = 1 << SHQ;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_GAIN  = 39797;
    localparam logic [18:0] CORDIC_ATAN [CORDIC_STEPS] = '{
        19'd184320, 19'd108810, 19'd57492, 19'd29184, 19'd14649, 19'd7331,
        19'd3667, 19'd1833, 19'd917, 19'd458, 19'd229, 19'd115, 19'd57,
        19'd29, 19'd14, 19'd7
    };

    // Actions and register indexes
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_RENDER = 1'b1;

    localparam logic [CIDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_CUBE_SIZE  = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_RAY_COUNT  = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ANGLE,
        S_TRIG_WAIT,
        S_PASS_SETUP,
        S_RATIO_WAIT,
        S_RATIO_MUL,
        S_START_POS,
        S_MARCH_ADDR,
        S_MARCH_CHECK,
        S_DIST_MX,
        S_DIST_MY,
        S_DIST_SUM,
        S_SQRT_WAIT,
        S_PASS_NEXT,
        S_SELECT,
        S_FISH_START,
        S_FISH_WAIT,
        S_LEN_MUL,
        S_LEN,
        S_HDIV_WAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
    } t_trig;

endpackage
`default_nettype wire

FILE: src/grc_map.sv
// Tile map memory with a clearing sweep after reset.
`default_nettype none
module grc_map (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_wr_en,
    input  wire logic [grc_pkg::ADDR_W-1:0] i_wr_addr,
    input  wire logic [grc_pkg::TILE_W-1:0] i_wr_data,
    input  wire logic [grc_pkg::ADDR_W-1:0] i_rd_addr,
    output logic      [grc_pkg::TILE_W-1:0] o_rd_data,
    output logic                            o_clearing
);
    import grc_pkg::*;

    logic [TILE_W-1:0] r_mem [MAP_CELLS];
    logic [ADDR_W:0]   r_clr;
    logic              r_clearing;
    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [TILE_W-1:0] wd;

    always_comb begin
        we = r_clearing || i_wr_en;
        wa = r_clearing ? r_clr[ADDR_W-1:0] : i_wr_addr;
        wd = r_clearing ? '0 : i_wr_data;
    end

    // Sweep every entry to zero once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_clearing <= 1'b1;
        end else if (r_clearing) begin
            r_clr <= r_clr + 1'b1;
            if (r_clr == (ADDR_W + 1)'(MAP_CELLS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

    assign o_clearing = r_clearing;

endmodule
`default_nettype wire

FILE: src/grc_cordic.sv
// Iterative CORDIC giving Q16 cosine and sine of an angle in sixteenths of a degree.
`default_nettype none
module grc_cordic (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_start,
    input  wire logic [grc_pkg::ANG_W-1:0]        i_angle,
    output logic                                  o_done,
    output logic signed [grc_pkg::TRIG_W-1:0]     o_cos,
    output logic signed [grc_pkg::TRIG_W-1:0]     o_sin
);
    import grc_pkg::*;

    logic signed [CX_W-1:0] r_x, r_y, n_x, n_y, xs, ys;
    logic signed [CZ_W-1:0] r_z, n_z, atan_k;
    logic [3:0]             r_k;
    logic [1:0]             r_q, q_in;
    logic [10:0]            rem_in;
    logic                   r_busy;
    logic                   r_done;
    t_trig                  exact_map, final_map;

    function automatic logic signed [CX_W-1:0] shr_trunc(
        input logic signed [CX_W-1:0] v, input logic [3:0] k);
        logic signed [CX_W-1:0] m;
        m = v[CX_W-1] ? -v : v;
        m = m >>> k;
        return v[CX_W-1] ? -m : m;
    endfunction

    function automatic logic signed [TRIG_W-1:0] clamp_unit(input logic signed [CX_W-1:0] v);
        logic signed [TRIG_W-1:0] r;
        if (v < CX_W'(1)) r = TRIG_W'(1);
        else if (v > CX_W'(ONE_Q16)) r = TRIG_W'(ONE_Q16);
        else r = v[TRIG_W-1:0];
        return r;
    endfunction

    function automatic t_trig quad_map(input logic [1:0] q,
                                       input logic signed [TRIG_W-1:0] c,
                                       input logic signed [TRIG_W-1:0] s);
        t_trig t;
        unique case (q)
            2'd0: begin t.c = c;  t.s = s;  end
            2'd1: begin t.c = -s; t.s = c;  end
            2'd2: begin t.c = -c; t.s = -s; end
            2'd3: begin t.c = s;  t.s = -c; end
        endcase
        return t;
    endfunction

    // Split the angle into quadrant and remainder
    always_comb begin
        priority if (i_angle < ANG_W'(QUARTER_TURN)) begin
            q_in   = 2'd0;
            rem_in = i_angle[10:0];
        end else if (i_angle < ANG_W'(2 * QUARTER_TURN)) begin
            q_in   = 2'd1;
            rem_in = 11'(i_angle - ANG_W'(QUARTER_TURN));
        end else if (i_angle < ANG_W'(3 * QUARTER_TURN)) begin
            q_in   = 2'd2;
            rem_in = 11'(i_angle - ANG_W'(2 * QUARTER_TURN));
        end else begin
            q_in   = 2'd3;
            rem_in = 11'(i_angle - ANG_W'(3 * QUARTER_TURN));
        end
    end

    always_comb begin
        xs     = shr_trunc(r_x, r_k);
        ys     = shr_trunc(r_y, r_k);
        atan_k = $signed({2'b00, CORDIC_ATAN[r_k]});
        if (!r_z[CZ_W-1]) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - atan_k;
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + atan_k;
        end
        exact_map = quad_map(q_in, TRIG_W'(ONE_Q16), '0);
        final_map = quad_map(r_q, clamp_unit(n_x), clamp_unit(n_y));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q <= q_in;
                if (rem_in == '0) begin
                    o_cos  <= exact_map.c;
                    o_sin  <= exact_map.s;
                    r_done <= 1'b1;
                end else begin
                    r_x    <= CX_W'(CORDIC_GAIN);
                    r_y    <= '0;
                    r_z    <= $signed({2'b00, rem_in, 8'b0});
                    r_k    <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                r_k <= r_k + 1'b1;
                if (r_k == 4'(CORDIC_STEPS - 1)) begin
                    o_cos  <= final_map.c;
                    o_sin  <= final_map.s;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;

endmodule
`default_nettype wire

FILE: src/grc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module grc_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [grc_pkg::DIVN_W-1:0] i_dividend,
    input  wire logic [grc_pkg::DIVD_W-1:0] i_divisor,
    output logic                            o_done,
    output logic      [grc_pkg::DIVN_W-1:0] o_quot
);
    import grc_pkg::*;

    logic [DIVD_W-1:0] r_rem, r_den, n_rem;
    logic [DIVN_W-1:0] r_quo;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy, r_done;
    logic [DIVD_W:0]   rem_sh, diff;
    logic              ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[DIVN_W-1]};
        diff   = rem_sh - {1'b0, r_den};
        ge     = rem_sh >= {1'b0, r_den};
        n_rem  = ge ? diff[DIVD_W-1:0] : rem_sh[DIVD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_den  <= i_divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[DIVN_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIVN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
`default_nettype wire

FILE: src/grc_sqrt.sv
// Bitwise integer square root, one result bit per cycle.
`default_nettype none
module grc_sqrt (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [grc_pkg::SQ_W-1:0]   i_value,
    output logic                            o_done,
    output logic      [grc_pkg::ROOT_W-1:0] o_root
);
    import grc_pkg::*;

    logic [SQ_W-1:0] r_v, r_res, r_bit, trial;
    logic            r_busy, r_done, ge;

    always_comb begin
        trial = r_res + r_bit;
        ge    = r_v >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_v    <= i_value;
                r_res  <= '0;
                r_bit  <= SQ_W'(1) << (SQ_W - 2);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (ge) begin
                    r_v   <= r_v - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit == SQ_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[ROOT_W-1:0];

endmodule
`default_nettype wire

FILE: src/grid_raycast_columns.sv
// Top level: ray sequencer, shared multiplier, map, trig, divide and root units.
// Map write: written to the map, no result. Render: per ray up to three divides
// (one ratio per pass and the line height), two 16-step CORDIC runs, two roots
// and up to 2 x MAX_STEPS map reads; a frame is ray_count rays, at most MAX_RAYS.
// Reset clears control state and starts a sweep that clears all 1024 map cells, during which
// no input item is taken; configuration writes are taken at all times.
`default_nettype none
module grid_raycast_columns (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration write channel
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [grc_pkg::CIDX_W-1:0]   i_cfg_index,
    input  wire logic [grc_pkg::CDATA_W-1:0]  i_cfg_data,
    // input items
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_action,
    input  wire logic [9:0]                   i_cell_index,
    input  wire logic [grc_pkg::TILE_W-1:0]   i_cell_value,
    input  wire logic [grc_pkg::POS_IN_W-1:0] i_player_x,
    input  wire logic [grc_pkg::POS_IN_W-1:0] i_player_y,
    input  wire logic [grc_pkg::ANG_W-1:0]    i_player_angle,
    // result items
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [5:0]                        o_column,
    output logic [grc_pkg::TILE_W-1:0]        o_wall_type,
    output logic                              o_hit_vertical,
    output logic [grc_pkg::POS_IN_W-1:0]      o_hit_x,
    output logic [grc_pkg::POS_IN_W-1:0]      o_hit_y,
    output logic [8:0]                        o_line_height,
    output logic [7:0]                        o_line_offset,
    output logic                              o_last
);
    import grc_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers; always ready
    // ---------------------------------------------------------------
    logic [5:0]       r_map_width, r_map_height;
    logic [7:0]       r_cube_size;
    logic [CNT_W-1:0] r_ray_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= 6'd8;
            r_map_height <= 6'd8;
            r_cube_size  <= 8'd64;
            r_ray_count  <= CNT_W'(60);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data[5:0];
                CFG_MAP_HEIGHT: r_map_height <= i_cfg_data[5:0];
                CFG_CUBE_SIZE:  r_cube_size  <= i_cfg_data;
                CFG_RAY_COUNT:  r_ray_count  <= i_cfg_data[CNT_W-1:0];
            endcase
        end
    end

    // ---------------------------------------------------------------
    // State and working registers
    // ---------------------------------------------------------------
    t_state r_state, n_state;

    logic [POS_IN_W-1:0]      r_px, r_py;
    logic [ANG_W-1:0]         r_pa, r_ray_ang;
    logic [CNT_W-1:0]         r_n, r_i;
    logic signed [TRIG_W-1:0] r_cos, r_sin;
    logic                     r_pass;          // 0 horizontal lines, 1 vertical lines
    logic signed [RATIO_W-1:0] r_ratio;
    logic signed [POS_W-1:0]  r_x, r_y, r_dx, r_dy;
    logic signed [POS_W-1:0]  r_hx, r_hy, r_vx, r_vy;
    logic [STEP_W-1:0]        r_step;
    logic                     r_cell_ok;
    logic [TILE_W-1:0]        r_ht, r_vt, r_wt;
    logic [ROOT_W-1:0]        r_hd, r_vd;
    logic [SQ_W-1:0]          r_sq;
    logic                     r_vert;
    logic [POS_IN_W-1:0]      r_ex, r_ey;
    logic [WHOLE_W-1:0]       r_whole;
    logic [8:0]               r_h;
    logic signed [PROD_W-1:0] r_prod;

    // Unit hookups
    logic                     cor_start, cor_done;
    logic [ANG_W-1:0]         cor_angle;
    logic signed [TRIG_W-1:0] cor_cos, cor_sin;
    logic                     div_start, div_done;
    logic [DIVN_W-1:0]        div_dividend, div_quot;
    logic [DIVD_W-1:0]        div_divisor;
    logic                     sq_start, sq_done;
    logic [SQ_W-1:0]          sq_value;
    logic [ROOT_W-1:0]        sq_root;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                     map_clearing;
    logic [TILE_W-1:0]        map_rd;
    logic                     map_we;

    // ---------------------------------------------------------------
    // Input side decode
    // ---------------------------------------------------------------
    logic             in_acc;
    logic [ANG_W-1:0] pa_red;
    logic [13:0]      start_sum;
    logic [ANG_W-1:0] start_ang;
    logic [CNT_W-1:0] n_calc;

    assign o_in_ready = (r_state == S_IDLE) && !map_clearing;
    assign in_acc     = i_in_valid && o_in_ready;
    assign map_we     = in_acc && (i_action == ACT_WRITE)
                        && ({1'b0, i_cell_index} < 11'(MAP_CELLS));

    always_comb begin
        pa_red    = (i_player_angle >= ANG_W'(FULL_TURN))
                    ? ANG_W'(i_player_angle - ANG_W'(FULL_TURN)) : i_player_angle;
        n_calc    = (r_ray_count > CNT_W'(MAX_RAYS)) ? CNT_W'(MAX_RAYS) : r_ray_count;
        // first ray sits half the view to the left: pa - (n/2) degrees
        start_sum = 14'({1'b0, pa_red}) + 14'(FULL_TURN)
                    - 14'({n_calc[CNT_W-1:1], 4'b0000});
        start_ang = (start_sum >= 14'(FULL_TURN))
                    ? ANG_W'(start_sum - 14'(FULL_TURN)) : start_sum[ANG_W-1:0];
    end

    // ---------------------------------------------------------------
    // Per-pass geometry: pass 0 steps across horizontal lines (major y),
    // pass 1 across vertical lines (major x)
    // ---------------------------------------------------------------
    logic signed [TRIG_W-1:0]  den, num;
    logic [POS_IN_W-1:0]       pm, pn, base;
    logic                      den_pos, ratio_neg;
    logic signed [MUL_A_W-1:0] m0, m_diff;
    logic [DIVD_W-1:0]         num_mag, den_mag;
    logic signed [POS_W-1:0]   ratio_ext, step_n, step_m, n0, m0_ext;
    logic signed [PROD_W-1:0]  prod_sh;

    always_comb begin
        den       = r_pass ? r_cos : r_sin;
        num       = r_pass ? r_sin : r_cos;
        pm        = r_pass ? r_px : r_py;
        pn        = r_pass ? r_py : r_px;
        den_pos   = !den[TRIG_W-1];
        ratio_neg = num[TRIG_W-1] ^ den[TRIG_W-1];
        num_mag   = num[TRIG_W-1] ? DIVD_W'(-num) : num[DIVD_W-1:0];
        den_mag   = den[TRIG_W-1] ? DIVD_W'(-den) : den[DIVD_W-1:0];
        base      = (pm >> SHQ) << SHQ;
        // first line ahead, or one LSB below the current line when heading back
        m0        = den_pos ? $signed(MUL_A_W'(base)) + MUL_A_W'(CELL_Q8)
                            : $signed(MUL_A_W'(base)) - MUL_A_W'(1);
        m_diff    = m0 - $signed(MUL_A_W'(pm));
        m0_ext    = POS_W'(m0);
        ratio_ext = {{(POS_W - RATIO_W){r_ratio[RATIO_W-1]}}, r_ratio};
        step_n    = (den_pos ? ratio_ext : -ratio_ext) >>> 2;
        step_m    = den_pos ? POS_W'(CELL_Q8) : -POS_W'(CELL_Q8);
        prod_sh   = r_prod >>> 16;
        n0        = $signed(POS_W'(pn)) + $signed(prod_sh[POS_W-1:0]);
    end

    // ---------------------------------------------------------------
    // Map cell lookup of the march point
    // ---------------------------------------------------------------
    logic              x_ok, y_ok, in_map;
    logic [11:0]       cell_idx;
    logic [TILE_W-1:0] tile;

    always_comb begin
        x_ok     = !r_x[POS_W-1]
                   && (r_x[POS_W-2:SHQ] < {{(CELLC_W - 6){1'b0}}, r_map_width});
        y_ok     = !r_y[POS_W-1]
                   && (r_y[POS_W-2:SHQ] < {{(CELLC_W - 6){1'b0}}, r_map_height});
        cell_idx = ({6'b0, r_y[SHQ+5:SHQ]} * {6'b0, r_map_width})
                   + {6'b0, r_x[SHQ+5:SHQ]};
        in_map   = x_ok && y_ok && ({1'b0, cell_idx} < 13'(MAP_CELLS));
        tile     = r_cell_ok ? map_rd : '0;
    end

    // ---------------------------------------------------------------
    // Ray finish: pick the nearer hit, fish-eye angle, height
    // ---------------------------------------------------------------
    logic signed [MUL_A_W-1:0] ddx, ddy;
    logic                      vert_sel, last_step, slot_free, len_ok;
    logic signed [POS_W-1:0]   ex_sel, ey_sel;
    logic [13:0]               fish_sum;
    logic [ANG_W-1:0]          fish_ang;
    logic [WHOLE_W-1:0]        len;
    logic [16:0]               height_num;
    logic [13:0]               next_sum;

    function automatic logic [POS_IN_W-1:0] clamp_pos(input logic signed [POS_W-1:0] v);
        logic [POS_IN_W-1:0] r;
        if (v[POS_W-1]) r = '0;
        else if (v > POS_W'(POS_MAX)) r = POS_IN_W'(POS_MAX);
        else r = v[POS_IN_W-1:0];
        return r;
    endfunction

    always_comb begin
        ddx        = $signed(r_x[MUL_A_W-1:0]) - $signed(MUL_A_W'(r_px));
        ddy        = $signed(r_y[MUL_A_W-1:0]) - $signed(MUL_A_W'(r_py));
        vert_sel   = (r_vt != '0) && ((r_ht == '0) || (r_hd > r_vd));
        ex_sel     = vert_sel ? r_vx : r_hx;
        ey_sel     = vert_sel ? r_vy : r_hy;
        last_step  = (r_step == STEP_W'(MAX_STEPS - 1));
        slot_free  = !o_out_valid || i_out_ready;
        fish_sum   = 14'({1'b0, r_pa}) + 14'(FULL_TURN) - 14'({1'b0, r_ray_ang});
        fish_ang   = (fish_sum >= 14'(FULL_TURN))
                     ? ANG_W'(fish_sum - 14'(FULL_TURN)) : fish_sum[ANG_W-1:0];
        len        = r_prod[16 + WHOLE_W - 1:16];
        len_ok     = !r_cos[TRIG_W-1] && (r_cos != '0) && (len != '0);
        height_num = {1'b0, r_cube_size, 8'b0} + {3'b0, r_cube_size, 6'b0};
        next_sum   = 14'({1'b0, r_ray_ang}) + 14'(DEG_UNITS);
    end

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:        if (in_acc && (i_action == ACT_RENDER) && (n_calc != '0))
                               n_state = S_ANGLE;
            S_ANGLE:       n_state = S_TRIG_WAIT;
            S_TRIG_WAIT:   if (cor_done) n_state = S_PASS_SETUP;
            S_PASS_SETUP:  n_state = (den == '0) ? S_PASS_NEXT : S_RATIO_WAIT;
            S_RATIO_WAIT:  if (div_done) n_state = S_RATIO_MUL;
            S_RATIO_MUL:   n_state = S_START_POS;
            S_START_POS:   n_state = S_MARCH_ADDR;
            S_MARCH_ADDR:  n_state = S_MARCH_CHECK;
            S_MARCH_CHECK: begin
                priority if (tile != '0) n_state = S_DIST_MX;
                else if (last_step)      n_state = S_PASS_NEXT;
                else                     n_state = S_MARCH_ADDR;
            end
            S_DIST_MX:     n_state = S_DIST_MY;
            S_DIST_MY:     n_state = S_DIST_SUM;
            S_DIST_SUM:    n_state = S_SQRT_WAIT;
            S_SQRT_WAIT:   if (sq_done) n_state = S_PASS_NEXT;
            S_PASS_NEXT:   n_state = r_pass ? S_SELECT : S_PASS_SETUP;
            S_SELECT:      n_state = ((vert_sel ? r_vt : r_ht) != '0) ? S_FISH_START : S_EMIT;
            S_FISH_START:  n_state = S_FISH_WAIT;
            S_FISH_WAIT:   if (cor_done) n_state = S_LEN_MUL;
            S_LEN_MUL:     n_state = S_LEN;
            S_LEN:         n_state = len_ok ? S_HDIV_WAIT : S_EMIT;
            S_HDIV_WAIT:   if (div_done) n_state = S_EMIT;
            S_EMIT:        if (slot_free)
                               n_state = (r_i + 1'b1 == r_n) ? S_IDLE : S_ANGLE;
            default:       n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: unit controls and shared multiplier operands
    // ---------------------------------------------------------------
    always_comb begin
        cor_start    = (r_state == S_ANGLE) || (r_state == S_FISH_START);
        cor_angle    = (r_state == S_ANGLE) ? r_ray_ang : fish_ang;
        div_start    = ((r_state == S_PASS_SETUP) && (den != '0))
                       || ((r_state == S_LEN) && len_ok);
        div_dividend = (r_state == S_LEN) ? DIVN_W'(height_num) : {num_mag, 16'b0};
        div_divisor  = (r_state == S_LEN) ? DIVD_W'(len) : den_mag;
        sq_start     = (r_state == S_DIST_SUM);
        sq_value     = r_sq + r_prod[SQ_W-1:0];
        mul_a        = '0;
        mul_b        = '0;
        unique case (r_state)
            S_RATIO_MUL: begin
                mul_a = m_diff;
                mul_b = r_ratio;
            end
            S_DIST_MX: begin
                mul_a = ddx;
                mul_b = MUL_B_W'(ddx);
            end
            S_DIST_MY: begin
                mul_a = ddy;
                mul_b = MUL_B_W'(ddy);
            end
            S_LEN_MUL: begin
                mul_a = $signed(MUL_A_W'(r_whole));
                mul_b = MUL_B_W'(r_cos);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ray_ang   <= '0;
            r_i         <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_EMIT) && slot_free) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if ((r_state == S_IDLE) && in_acc && (i_action == ACT_RENDER)) begin
                r_ray_ang <= start_ang;
                r_i       <= '0;
            end else if ((r_state == S_EMIT) && slot_free) begin
                r_i       <= r_i + 1'b1;
                r_ray_ang <= (next_sum >= 14'(FULL_TURN))
                             ? ANG_W'(next_sum - 14'(FULL_TURN)) : next_sum[ANG_W-1:0];
            end
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_action == ACT_RENDER)) begin
                    r_px <= i_player_x;
                    r_py <= i_player_y;
                    r_pa <= pa_red;
                    r_n  <= n_calc;
                end
            end
            S_ANGLE: begin
                // no hit yet: the end point stays at the player
                r_ht   <= '0;
                r_vt   <= '0;
                r_hd   <= '0;
                r_vd   <= '0;
                r_hx   <= POS_W'(r_px);
                r_hy   <= POS_W'(r_py);
                r_vx   <= POS_W'(r_px);
                r_vy   <= POS_W'(r_py);
                r_pass <= 1'b0;
            end
            S_TRIG_WAIT: begin
                if (cor_done) begin
                    r_cos <= cor_cos;
                    r_sin <= cor_sin;
                end
            end
            S_RATIO_WAIT: begin
                if (div_done) begin
                    r_ratio <= ratio_neg ? -$signed(RATIO_W'(div_quot))
                                         : $signed(RATIO_W'(div_quot));
                end
            end
            S_START_POS: begin
                r_step <= '0;
                if (r_pass) begin
                    r_x  <= m0_ext;
                    r_y  <= n0;
                    r_dx <= step_m;
                    r_dy <= step_n;
                end else begin
                    r_x  <= n0;
                    r_y  <= m0_ext;
                    r_dx <= step_n;
                    r_dy <= step_m;
                end
            end
            S_MARCH_ADDR: begin
                r_cell_ok <= in_map;
            end
            S_MARCH_CHECK: begin
                if (tile != '0) begin
                    if (r_pass) begin
                        r_vt <= tile;
                        r_vx <= r_x;
                        r_vy <= r_y;
                    end else begin
                        r_ht <= tile;
                        r_hx <= r_x;
                        r_hy <= r_y;
                    end
                end else begin
                    r_x    <= r_x + r_dx;
                    r_y    <= r_y + r_dy;
                    r_step <= r_step + 1'b1;
                end
            end
            S_DIST_MY: begin
                r_sq <= r_prod[SQ_W-1:0];
            end
            S_SQRT_WAIT: begin
                if (sq_done) begin
                    if (r_pass) r_vd <= sq_root;
                    else        r_hd <= sq_root;
                end
            end
            S_PASS_NEXT: begin
                r_pass <= 1'b1;
            end
            S_SELECT: begin
                r_vert  <= vert_sel;
                r_wt    <= vert_sel ? r_vt : r_ht;
                r_ex    <= clamp_pos(ex_sel);
                r_ey    <= clamp_pos(ey_sel);
                r_whole <= vert_sel ? r_vd[ROOT_W-1:8] : r_hd[ROOT_W-1:8];
                r_h     <= '0;
            end
            S_FISH_WAIT: begin
                if (cor_done) begin
                    r_cos <= cor_cos;
                end
            end
            S_HDIV_WAIT: begin
                if (div_done) begin
                    r_h <= (div_quot > DIVN_W'(SCREEN_H)) ? 9'(SCREEN_H) : div_quot[8:0];
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    o_column       <= r_i[5:0];
                    o_wall_type    <= r_wt;
                    o_hit_vertical <= r_vert;
                    o_hit_x        <= r_ex;
                    o_hit_y        <= r_ey;
                    o_line_height  <= r_h;
                    o_line_offset  <= 8'(9'(SCREEN_MID) - 9'((10'(r_h) + 10'd1) >> 1));
                    o_last         <= (r_i + 1'b1 == r_n);
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Units
    // ---------------------------------------------------------------
    grc_map u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (map_we),
        .i_wr_addr  (i_cell_index[ADDR_W-1:0]),
        .i_wr_data  (i_cell_value),
        .i_rd_addr  (cell_idx[ADDR_W-1:0]),
        .o_rd_data  (map_rd),
        .o_clearing (map_clearing)
    );

    grc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_angle (cor_angle),
        .o_done  (cor_done),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    grc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    grc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (sq_value),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

endmodule
`default_nettype wire
